// ----- rtl/lcenc_pkg.sv -----
// Shared types, constants and tables for the location code encoder.
// No dependencies; every rtl file imports this package.
package lcenc_pkg;

	localparam int NSTEP = 9;     // divide steps per lane (five pair, four grid)
	localparam int DIGW  = 5;     // one base-20 digit
	localparam int LENW  = 4;     // clamped digit count
	localparam int NCHAR = 16;    // longest code in characters
	localparam int CNTW  = 5;     // holds 0..NCHAR
	localparam int LAT0W = 33;    // shifted latitude, 0 .. 180 degrees
	localparam int LON0W = 32;    // wrapped longitude, 0 .. 360 degrees
	localparam int LOW_W = 19;    // low longitude bits kept through the wrap
	localparam int WRAPW = 18;    // offset high longitude part
	localparam int PAIR_LEN = 10;
	localparam int SEP_POS  = 8;

	localparam logic signed [34:0] LAT_90  = 35'sd2250000000;
	localparam logic signed [35:0] LON_180 = 36'sd1474560000;
	// 360 degrees is 5625 * 2^19 units; wrap the bits above bit 18 modulo 5625
	localparam longint unsigned WRAP_DIV = 5625;
	localparam logic signed [WRAPW-1:0] WRAP_BIAS = 18'sd67500;   // 12 * 5625

	localparam logic [6:0] CHAR_PLUS = 7'h2b;
	localparam logic [6:0] CHAR_ZERO = 7'h30;

	localparam logic [6:0] DIGIT_SET [20] = '{
		7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h43, 7'h46,
		7'h47, 7'h48, 7'h4a, 7'h4d, 7'h50, 7'h51, 7'h52, 7'h56, 7'h57, 7'h58
	};

	// half latitude cell, rounded up, per clamped digit count
	localparam logic [27:0] POLAR_DROP [16] = '{
		28'd250000000, 28'd250000000, 28'd250000000, 28'd12500000, 28'd12500000,
		28'd625000, 28'd625000, 28'd31250, 28'd31250, 28'd1563, 28'd1563,
		28'd313, 28'd63, 28'd13, 28'd3, 28'd1
	};

	// cell edges per step: five pair steps, then four grid steps
	localparam longint unsigned LAT_DIV [NSTEP] = '{
		500000000, 25000000, 1250000, 62500, 3125, 625, 125, 25, 5
	};
	localparam longint unsigned LON_DIV [NSTEP] = '{
		163840000, 8192000, 409600, 20480, 1024, 256, 64, 16, 4
	};

	typedef struct packed {
		logic [LENW-1:0]                len;
		logic [NSTEP-1:0][DIGW-1:0]     latd;
		logic [NSTEP-1:0][DIGW-1:0]     lond;
	} tag_t;

	function automatic int lat_xw(int k);
		if (k == 0)
			return LAT0W;
		return $clog2(LAT_DIV[k-1]);
	endfunction

	function automatic int lon_xw(int k);
		if (k == 0)
			return LON0W;
		return $clog2(LON_DIV[k-1]);
	endfunction

endpackage

// ----- rtl/lcenc_div_step.sv -----
// One pipelined digit step: quotient (below 32) and remainder of x by a constant.
// Two register stages, reciprocal multiply then one correction; uses lcenc_pkg.
module lcenc_div_step #(
	parameter int XW = 18,
	parameter longint unsigned D = 5625
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [XW-1:0]              x,
	output logic [lcenc_pkg::DIGW-1:0] q,
	output logic [$clog2(D)-1:0]       rem
);
	import lcenc_pkg::*;

	localparam int OW = $clog2(D);
	// x < 2^XW, so the estimate is the quotient or one below it
	localparam longint unsigned R = (64'd1 << XW) / D;
	localparam int RW = $clog2(R + 1);
	localparam logic [RW-1:0] RC = RW'(R);
	localparam logic [XW-1:0] DC = XW'(D);

	logic [XW-1:0]    x_s1;
	logic [XW+RW-1:0] prod_s1;
	logic [DIGW-1:0]  q_est, q_n;
	logic [XW-1:0]    r_est, r_n;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			prod_s1 <= (XW+RW)'(x) * (XW+RW)'(RC);
		end
	end

	always_comb begin
		q_est = DIGW'(prod_s1 >> XW);
		r_est = x_s1 - XW'(q_est) * DC;
		q_n   = q_est;
		r_n   = r_est;
		if (r_est >= DC) begin
			q_n = q_est + DIGW'(1);
			r_n = r_est - DC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q   <= q_n;
			rem <= OW'(r_n);
		end
	end

endmodule

// ----- rtl/location_code_encoder_core.sv -----
// Location code encoder: fixed-point position in, code characters out.
// Input word: latitude_fixed, longitude_fixed, code_digits on in_valid/in_ready.
// Output word: one ASCII character per transfer on out_valid/out_ready, with
// last_char high on the final character of each code. A code is 9 to 16
// characters long depending on code_digits.
// The first character of a code reaches the output after its input word passes
// the front stage, two wrap stages, nine two-stage digit steps per lane and
// then the character buffer. A new input word can enter every cycle
// while the pipeline moves; sustained throughput is set by the single output
// character buffer, which sends one character per transfer.
// A finished code goes to the buffer in the cycle its predecessor's last
// character leaves, so codes stream without gaps.
// When the receiver stalls, the buffer holds and the pipeline keeps moving
// until a code reaches its last stage, then freezes as a whole; nothing is
// lost or repeated. in_ready drops once the last stage holds a code that the
// buffer cannot take.
// Reset clears all valid bits and empties the buffer; no pass is needed.
// Depends on lcenc_pkg and lcenc_div_step.
module location_code_encoder_core #(
	parameter int MAX_DIGITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [33:0] latitude_fixed,
	input  logic signed [34:0] longitude_fixed,
	input  logic [5:0]         code_digits,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         code_char,
	output logic               last_char
);
	import lcenc_pkg::*;

	localparam logic [LENW-1:0] LEN_MAX = LENW'(MAX_DIGITS);

	logic en, load;

	// ---------------- front: clamp, polar drop, offsets ----------------
	logic [LENW-1:0]         len_c;
	logic signed [34:0]      lat_x, lat_sum;
	logic signed [35:0]      lon_t;
	logic signed [16:0]      lon_h;
	logic signed [WRAPW-1:0] wrap_sg;

	always_comb begin
		len_c = (code_digits > 6'(MAX_DIGITS)) ? LEN_MAX : code_digits[LENW-1:0];
		lat_x = 35'(latitude_fixed);
		if (lat_x < -LAT_90)
			lat_x = -LAT_90;
		else if (lat_x >= LAT_90)
			lat_x = LAT_90 - signed'(35'(POLAR_DROP[len_c]));
		lat_sum = lat_x + LAT_90;
		lon_t   = 36'(longitude_fixed) + LON_180;
		lon_h   = lon_t[35:19];
		wrap_sg = WRAPW'(lon_h) + WRAP_BIAS;
	end

	logic                v_s1, v_s2, v_s3;
	logic [LAT0W-1:0]    lat0_s1, lat0_s2, lat0_s3;
	logic [WRAPW-1:0]    wrap_s1;
	logic [LOW_W-1:0]    lo_s1, lo_s2, lo_s3;
	logic [LENW-1:0]     len_s1, len_s2, len_s3;
	logic [DIGW-1:0]     wrap_q;
	logic [LON0W-LOW_W-1:0] wrap_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat0_s1 <= lat_sum[LAT0W-1:0];
			wrap_s1 <= unsigned'(wrap_sg);
			lo_s1   <= lon_t[LOW_W-1:0];
			len_s1  <= len_c;
			lat0_s2 <= lat0_s1;
			lo_s2   <= lo_s1;
			len_s2  <= len_s1;
			lat0_s3 <= lat0_s2;
			lo_s3   <= lo_s2;
			len_s3  <= len_s2;
		end
	end

	// longitude modulo 360 degrees: high part modulo 5625, low bits pass
	lcenc_div_step #(.XW(WRAPW), .D(WRAP_DIV)) u_wrap (
		.clk (clk),
		.en  (en),
		.x   (wrap_s1),
		.q   (wrap_q),
		.rem (wrap_rem)
	);

	// ---------------- digit steps ----------------
	logic [LAT0W-1:0] lat_r [0:NSTEP];
	logic [LON0W-1:0] lon_r [0:NSTEP];
	tag_t             tag_w [0:NSTEP];
	logic             v_w   [0:NSTEP];

	assign tag_w[0] = {len_s3, {(2 * NSTEP * DIGW){1'b0}}};
	assign v_w[0]   = v_s3;
	assign lat_r[0] = lat0_s3;
	assign lon_r[0] = {wrap_rem, lo_s3};

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int LXW = lat_xw(k);
		localparam int OXW = lon_xw(k);
		localparam int LOW = $clog2(LAT_DIV[k]);
		localparam int OOW = $clog2(LON_DIV[k]);

		logic [DIGW-1:0] lat_q, lon_q;
		logic [LOW-1:0]  lat_rem;
		logic [OOW-1:0]  lon_rem;
		logic            v_s1, v_s2;
		tag_t            tag_s1, tag_s2, tag_o;

		lcenc_div_step #(.XW(LXW), .D(LAT_DIV[k])) u_lat (
			.clk (clk),
			.en  (en),
			.x   (lat_r[k][LXW-1:0]),
			.q   (lat_q),
			.rem (lat_rem)
		);

		lcenc_div_step #(.XW(OXW), .D(LON_DIV[k])) u_lon (
			.clk (clk),
			.en  (en),
			.x   (lon_r[k][OXW-1:0]),
			.q   (lon_q),
			.rem (lon_rem)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else if (en) begin
				v_s1 <= v_w[k];
				v_s2 <= v_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s1 <= tag_w[k];
				tag_s2 <= tag_s1;
			end
		end

		always_comb begin
			tag_o         = tag_s2;
			tag_o.latd[k] = lat_q;
			tag_o.lond[k] = lon_q;
		end

		assign tag_w[k+1] = tag_o;
		assign v_w[k+1]   = v_s2;
		assign lat_r[k+1] = LAT0W'(lat_rem);
		assign lon_r[k+1] = LON0W'(lon_rem);
	end

	// ---------------- character assembly ----------------
	tag_t            tg;
	logic [6:0]      chars [NCHAR];
	logic [CNTW-1:0] n_chars;
	logic [LENW-1:0] pair_d, n_pair;
	logic [DIGW-1:0] row, col, grid_idx;

	always_comb begin
		tg     = tag_w[NSTEP];
		pair_d = (tg.len > LENW'(PAIR_LEN)) ? LENW'(PAIR_LEN) : tg.len;
		// odd counts round up to a full pair
		n_pair = (pair_d + LENW'(1)) & ~LENW'(1);
		for (int i = 0; i < SEP_POS; i++) begin
			if (LENW'(i) < n_pair)
				chars[i] = (i % 2 == 0) ? DIGIT_SET[tg.latd[i/2]] : DIGIT_SET[tg.lond[i/2]];
			else
				chars[i] = CHAR_ZERO;
		end
		chars[SEP_POS]     = CHAR_PLUS;
		chars[SEP_POS + 1] = DIGIT_SET[tg.latd[4]];
		chars[SEP_POS + 2] = DIGIT_SET[tg.lond[4]];
		for (int g = 0; g < NSTEP - 5; g++) begin
			row      = tg.latd[5+g];
			col      = tg.lond[5+g];
			grid_idx = DIGW'({row[2:0], col[1:0]});
			chars[PAIR_LEN + 1 + g] = DIGIT_SET[grid_idx];
		end
		// the last grid digit is the remainder of the final step
		row      = DIGW'(lat_r[NSTEP][2:0]);
		col      = DIGW'(lon_r[NSTEP][1:0]);
		grid_idx = DIGW'({row[2:0], col[1:0]});
		chars[NCHAR - 1] = DIGIT_SET[grid_idx];
		n_chars = CNTW'(SEP_POS + 1);
		if (n_pair == LENW'(PAIR_LEN))
			n_chars = n_chars + CNTW'(2);
		if (tg.len > LENW'(PAIR_LEN))
			n_chars = n_chars + CNTW'(tg.len - LENW'(PAIR_LEN));
	end

	// ---------------- output character buffer ----------------
	logic [6:0]      buf_q [NCHAR];
	logic [CNTW-1:0] cnt_q;
	logic            out_take;

	assign out_valid = (cnt_q != '0);
	assign out_take  = out_valid && out_ready;
	assign code_char = buf_q[0];
	assign last_char = (cnt_q == CNTW'(1));
	assign load      = v_w[NSTEP] && ((cnt_q == '0) || (last_char && out_ready));
	assign en        = !v_w[NSTEP] || load;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_chars;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= chars;
		end else if (out_take) begin
			// advance to the next character
			for (int i = 0; i < NCHAR - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

	// ---------------- assertions ----------------
	a_load_len: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q >= CNTW'(SEP_POS + 1)) && (cnt_q <= CNTW'(NCHAR)))
		else $error("code length out of range after load");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_w[NSTEP]) |=> v_w[NSTEP])
		else $error("stalled code dropped from last stage");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !last_char) |=> out_valid)
		else $error("code broke off before its last character");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (code_char >= CHAR_PLUS) && (code_char <= DIGIT_SET[19]))
		else $error("character outside code alphabet");

endmodule
